// ===== rtl/ascache_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascache_pkg
// Shared types and constants for the timed slot cache.
// ----------------------------------------------------------------------------
package ascache_pkg;

	typedef enum logic [1:0] {
		FN_LOOKUP = 2'd0,
		FN_ALLOC  = 2'd1,
		FN_INVAL  = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FILL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [16:0] owner;
		logic signed [33:0] expiry;
	} entry_t;

	typedef struct packed {
		logic       found;
		logic [7:0] slot_index;
	} res_t;

	localparam logic signed [16:0] OWNER_NONE  = -17'sd1;
	localparam logic signed [33:0] EXPIRY_NONE = -34'sd1;
	localparam entry_t             ENTRY_FREE  = '{owner: OWNER_NONE, expiry: EXPIRY_NONE};

endpackage

// ===== rtl/ascache_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascache_mem
// Slot table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ascache_mem
	import ascache_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/ascache_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascache_ctrl
// Request sequencer: table sweep, pipelined scan, run fill and write-back.
// ----------------------------------------------------------------------------
module ascache_ctrl
	import ascache_pkg::*;
#(
	parameter int SLOT_TOTAL = 256,
	parameter int AW         = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  func_t              req_func,
	input  logic signed [16:0] req_owner,
	input  logic [4:0]         req_count,
	input  logic [30:0]        req_now,
	input  logic [31:0]        ticks,
	output logic               res_valid,
	input  logic               res_take,
	output res_t               res,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output entry_t             mem_wdata,
	output logic [AW-1:0]      mem_raddr,
	input  entry_t             mem_rdata
);

	localparam int SW = ((AW > 5) ? AW : 5) + 2;
	localparam int IW = (AW > 8) ? AW : 8;

	state_t             state_q, state_d;
	func_t              func_q;
	logic signed [16:0] owner_q;
	logic [4:0]         count_q;
	logic [30:0]        now_q;
	logic signed [33:0] stamp_q;
	logic [AW:0]        issue_q;
	logic               rv_s1;
	logic [AW-1:0]      ridx_s1;
	logic [AW-1:0]      fill_addr_q;
	logic [4:0]         fill_left_q;
	logic               boot_q;
	res_t               res_q;

	logic               accept;
	logic               issue_more;
	logic               own_eq;
	logic               expired;
	logic               end_fail;
	logic               last;
	logic               scan_hit;
	logic               scan_fail;
	logic               sweep_end;
	logic [SW-1:0]      run_end;
	logic [IW-1:0]      ridx_w;

	assign accept     = req_valid && req_ready;
	assign issue_more = issue_q < (AW+1)'(SLOT_TOTAL);
	assign own_eq     = mem_rdata.owner == owner_q;
	assign expired    = mem_rdata.expiry < $signed({3'b000, now_q});
	assign run_end    = SW'(ridx_s1) + SW'(count_q);
	assign end_fail   = run_end > SW'(SLOT_TOTAL);
	assign last       = ridx_s1 == AW'(SLOT_TOTAL - 1);
	assign sweep_end  = issue_q == (AW+1)'(SLOT_TOTAL - 1);
	assign ridx_w     = IW'(ridx_s1);

	always_comb begin
		scan_hit  = 1'b0;
		scan_fail = 1'b0;
		if (state_q == ST_SCAN && rv_s1) begin
			unique case (func_q)
				FN_ALLOC: begin
					scan_hit  = !end_fail && expired;
					scan_fail = end_fail || (!expired && last);
				end
				FN_LOOKUP, FN_INVAL: begin
					scan_hit  = own_eq;
					scan_fail = !own_eq && last;
				end
				FN_CLEAR: begin
					scan_hit  = 1'b0;
					scan_fail = 1'b0;
				end
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sweep_end) begin
					state_d = boot_q ? ST_IDLE : ST_DONE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (req_func == FN_CLEAR) begin
						state_d = ST_CLEAR;
					end else if (req_func == FN_LOOKUP && req_owner == OWNER_NONE) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (scan_hit) begin
					state_d = (func_q == FN_ALLOC && count_q != 5'd0) ? ST_FILL : ST_DONE;
				end else if (scan_fail) begin
					state_d = ST_DONE;
				end
			end
			ST_FILL: begin
				if (fill_left_q == 5'd1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready = state_q == ST_IDLE;
		res_valid = state_q == ST_DONE;
		res       = res_q;
		mem_raddr = issue_q[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = ridx_s1;
		mem_wdata = ENTRY_FREE;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = issue_q[AW-1:0];
			end
			ST_SCAN: begin
				if (scan_hit && func_q == FN_LOOKUP) begin
					mem_we    = 1'b1;
					mem_wdata = '{owner: mem_rdata.owner, expiry: stamp_q};
				end else if (scan_hit && func_q == FN_INVAL) begin
					mem_we = 1'b1;
				end
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = fill_addr_q;
				mem_wdata = '{owner: owner_q, expiry: stamp_q};
			end
			ST_IDLE, ST_DONE: begin
				mem_we = 1'b0;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			issue_q <= '0;
			rv_s1   <= 1'b0;
			boot_q  <= 1'b1;
			res_q   <= '0;
		end else begin
			state_q <= state_d;
			rv_s1   <= state_q == ST_SCAN && state_d == ST_SCAN && issue_more;
			if (state_q == ST_IDLE) begin
				issue_q <= '0;
			end else if ((state_q == ST_SCAN && issue_more) || state_q == ST_CLEAR) begin
				issue_q <= issue_q + (AW+1)'(1);
			end
			if (state_q == ST_CLEAR && sweep_end) begin
				boot_q <= 1'b0;
				res_q  <= '{found: 1'b1, slot_index: 8'd0};
			end
			if (accept) begin
				res_q <= '0;
			end
			if (scan_hit) begin
				res_q <= '{found: 1'b1, slot_index: ridx_w[7:0]};
			end else if (scan_fail) begin
				res_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= issue_q[AW-1:0];
		if (accept) begin
			func_q  <= req_func;
			owner_q <= req_owner;
			count_q <= req_count;
			now_q   <= req_now;
			stamp_q <= $signed(34'(req_now) + 34'(ticks));
		end
		if (scan_hit) begin
			fill_addr_q <= ridx_s1;
			fill_left_q <= count_q;
		end else if (state_q == ST_FILL) begin
			fill_addr_q <= fill_addr_q + AW'(1);
			fill_left_q <= fill_left_q - 5'd1;
		end
	end

endmodule

// ===== rtl/atlas_slot_cache_with_expiry_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atlas_slot_cache_with_expiry_core
// Timed slot cache with first-fit allocation over a SLOTS_PER_AXIS^2 table.
// ----------------------------------------------------------------------------
// One request at a time. The table sits in a single-port-read RAM and each
// request but a lookup of owner -1 walks it from slot 0 at one slot per clock,
// so the cost is set by that read port and the table size (SLOTS_PER_AXIS^2
// slots, 256 at the default). Allocate then writes each claimed slot; a granted
// run ends inside the table. A lookup of owner -1 reads no slot. After reset
// the table is swept before the first word is taken; configuration writes are
// taken at any time. A finished result waits in an output register while the
// next word is accepted.
// ----------------------------------------------------------------------------
module atlas_slot_cache_with_expiry_core
	import ascache_pkg::*;
#(
	parameter int SLOTS_PER_AXIS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [31:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic signed [16:0] owner_id,
	input  logic [4:0]         slice_count,
	input  logic [30:0]        now_time,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic [7:0]         slot_index
);

	localparam int SLOT_TOTAL = SLOTS_PER_AXIS * SLOTS_PER_AXIS;
	localparam int AW         = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;

	logic [31:0]   ticks_q;
	logic          out_valid_q;
	res_t          out_q;
	logic          req_ready;
	logic          res_valid;
	logic          res_take;
	res_t          res;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_rdata;

	assign in_stall   = !req_ready;
	assign res_take   = res_valid && (!out_valid_q || !out_stall);
	assign out_valid  = out_valid_q;
	assign found      = out_q.found;
	assign slot_index = out_q.slot_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q     <= 32'd5000;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				ticks_q <= cfg_wr_data;
			end
			if (res_take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	ascache_ctrl #(
		.SLOT_TOTAL (SLOT_TOTAL),
		.AW         (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req_ready (req_ready),
		.req_func  (func_t'(func)),
		.req_owner (owner_id),
		.req_count (slice_count),
		.req_now   (now_time),
		.ticks     (ticks_q),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ascache_mem #(
		.DEPTH (SLOT_TOTAL),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("word accepted on consecutive cycles");

	a_miss_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> slot_index == 8'd0)
		else $error("miss with nonzero slot index");

	a_out_from_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(res_valid))
		else $error("result shown without a finished request");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !mem_we)
		else $error("table written while idle");

endmodule
